// ===== hdl/lst_pkg.sv =====
// Shared types and constants for the LCD scan-line timing block.
package lst_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_LCD_ENABLE       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_COMPARE     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HBLANK_IRQ_EN    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_VBLANK_IRQ_EN    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OAM_IRQ_EN       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_COINCIDENCE_IRQ_EN = 3'd5;

  typedef enum logic [1:0] {
    MODE_HBLANK   = 2'd0,
    MODE_VBLANK   = 2'd1,
    MODE_OAM      = 2'd2,
    MODE_TRANSFER = 2'd3
  } lcd_mode_t;

  typedef struct packed {
    logic       lcd_enable;
    logic [7:0] line_compare;
    logic       hblank_irq_enable;
    logic       vblank_irq_enable;
    logic       oam_irq_enable;
    logic       coincidence_irq_enable;
  } cfg_t;

  typedef struct packed {
    logic [8:0] cycles_left;
    logic [7:0] line;
    lcd_mode_t  mode;
    logic       coincidence;
    logic       vblank_request;
    logic       stat_request;
    logic       draw_strobe;
  } step_t;

endpackage

// ===== hdl/lcd_scanline_timing.sv =====
// The result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle; in_ready stays high while the output
//   register is empty or being drained in the same cycle.
// Reset (rst, synchronous): line timer LINE_CYCLES, line 0, mode hblank,
//   LCD enabled, compare 0, interrupt enables clear, output register empty.
module lcd_scanline_timing #(
  parameter int LINE_CYCLES   = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int LAST_LINE     = 153,
  parameter int OAM_CYCLES    = 80,
  parameter int HBLANK_START  = 252
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lst_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lst_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [5:0]                        elapsed_cycles,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        line_number,
  output logic [1:0]                        lcd_mode,
  output logic                              coincidence,
  output logic                              vblank_request,
  output logic                              stat_request,
  output logic                              draw_strobe
);

  lst_pkg::cfg_t      cfg;
  logic [8:0]         cycles_left;
  logic [7:0]         current_line;
  lst_pkg::lcd_mode_t previous_mode;
  lst_pkg::step_t     step;
  logic               accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  lst_step_logic #(
    .LINE_CYCLES   (LINE_CYCLES),
    .VISIBLE_LINES (VISIBLE_LINES),
    .LAST_LINE     (LAST_LINE),
    .OAM_CYCLES    (OAM_CYCLES),
    .HBLANK_START  (HBLANK_START)
  ) u_step (
    .cycles_left    (cycles_left),
    .current_line   (current_line),
    .previous_mode  (previous_mode),
    .cfg            (cfg),
    .elapsed_cycles (elapsed_cycles),
    .step           (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lcd_enable             <= 1'b1;
      cfg.line_compare           <= 8'd0;
      cfg.hblank_irq_enable      <= 1'b0;
      cfg.vblank_irq_enable      <= 1'b0;
      cfg.oam_irq_enable         <= 1'b0;
      cfg.coincidence_irq_enable <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        lst_pkg::REG_LCD_ENABLE:         cfg.lcd_enable             <= cfg_data[0];
        lst_pkg::REG_LINE_COMPARE:       cfg.line_compare           <= cfg_data[7:0];
        lst_pkg::REG_HBLANK_IRQ_EN:      cfg.hblank_irq_enable      <= cfg_data[0];
        lst_pkg::REG_VBLANK_IRQ_EN:      cfg.vblank_irq_enable      <= cfg_data[0];
        lst_pkg::REG_OAM_IRQ_EN:         cfg.oam_irq_enable         <= cfg_data[0];
        lst_pkg::REG_COINCIDENCE_IRQ_EN: cfg.coincidence_irq_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_left   <= 9'(LINE_CYCLES);
      current_line  <= 8'd0;
      previous_mode <= lst_pkg::MODE_HBLANK;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        cycles_left   <= step.cycles_left;
        current_line  <= step.line;
        previous_mode <= step.mode;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (accept) begin
      line_number    <= step.line;
      lcd_mode       <= step.mode;
      coincidence    <= step.coincidence;
      vblank_request <= step.vblank_request;
      stat_request   <= step.stat_request;
      draw_strobe    <= step.draw_strobe;
    end
  end

`ifndef NO_ASSERTIONS
  a_timer_nonzero: assert property (@(posedge clk) disable iff (rst)
    cycles_left != 9'd0)
    else $error("line timer reached zero");

  a_line_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, current_line} <= 9'(LAST_LINE))
    else $error("line counter beyond last line");

  a_vblank_draw_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(vblank_request && draw_strobe))
    else $error("vblank and draw in the same word");

  a_disabled_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && !cfg.lcd_enable) |=> ($stable(cycles_left) && $stable(current_line)))
    else $error("timer moved while LCD disabled");

  a_mode_tracked: assert property (@(posedge clk) disable iff (rst)
    accept |=> previous_mode == lst_pkg::lcd_mode_t'(lcd_mode))
    else $error("previous mode does not match delivered mode");
`endif

endmodule

// ===== hdl/lst_step_logic.sv =====
// Combinational status, line timer and line counter update for one word.
module lst_step_logic #(
  parameter int LINE_CYCLES   = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int LAST_LINE     = 153,
  parameter int OAM_CYCLES    = 80,
  parameter int HBLANK_START  = 252
) (
  input  logic [8:0]         cycles_left,
  input  logic [7:0]         current_line,
  input  lst_pkg::lcd_mode_t previous_mode,
  input  lst_pkg::cfg_t      cfg,
  input  logic [5:0]         elapsed_cycles,
  output lst_pkg::step_t     step
);

  localparam logic [8:0] LINE_CYC = 9'(LINE_CYCLES);
  localparam logic [8:0] VIS_LINE = 9'(VISIBLE_LINES);
  localparam logic [8:0] LAST_LN  = 9'(LAST_LINE);
  localparam logic [8:0] OAM_CYC  = 9'(OAM_CYCLES);
  localparam logic [8:0] HB_START = 9'(HBLANK_START);

  logic [8:0] offset;
  logic [8:0] line_inc;
  logic [8:0] remain;
  logic       run_out;
  logic       mode_irq_en;

  assign offset   = LINE_CYC - cycles_left;
  assign line_inc = {1'b0, current_line} + 9'd1;
  assign remain   = cycles_left - {3'b000, elapsed_cycles};
  assign run_out  = {3'b000, elapsed_cycles} >= cycles_left;

  always_comb begin
    step = '0;
    if ({1'b0, current_line} >= VIS_LINE) begin
      step.mode = lst_pkg::MODE_VBLANK;
    end else if (offset < OAM_CYC) begin
      step.mode = lst_pkg::MODE_OAM;
    end else if (offset < HB_START) begin
      step.mode = lst_pkg::MODE_TRANSFER;
    end else begin
      step.mode = lst_pkg::MODE_HBLANK;
    end

    case (step.mode)
      lst_pkg::MODE_HBLANK: mode_irq_en = cfg.hblank_irq_enable;
      lst_pkg::MODE_VBLANK: mode_irq_en = cfg.vblank_irq_enable;
      lst_pkg::MODE_OAM:    mode_irq_en = cfg.oam_irq_enable;
      default:              mode_irq_en = 1'b0;
    endcase

    step.coincidence  = current_line == cfg.line_compare;
    step.stat_request = ((step.mode != previous_mode) && mode_irq_en) ||
                        (step.coincidence && cfg.coincidence_irq_enable);

    step.cycles_left = cycles_left;
    step.line        = current_line;
    if (cfg.lcd_enable) begin
      if (run_out) begin
        step.cycles_left = LINE_CYC;
        step.line        = line_inc[7:0];
        if (line_inc == VIS_LINE) begin
          step.vblank_request = 1'b1;
        end else if (line_inc > LAST_LN) begin
          step.line = 8'd0;
        end else if (line_inc < VIS_LINE) begin
          step.draw_strobe = 1'b1;
        end
      end else begin
        step.cycles_left = remain;
      end
    end
  end

endmodule

// ===== test/lcd_scanline_timing_tb.sv =====
// Testbench for lcd_scanline_timing: random and directed steps scored against a line-timer model.
`timescale 1ns / 1ps

module lcd_scanline_timing_tb;

  localparam int LINE_CYCLES   = 456;
  localparam int VISIBLE_LINES = 144;
  localparam int LAST_LINE     = 153;
  localparam int OAM_CYCLES    = 80;
  localparam int HBLANK_START  = 252;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam logic [lst_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [lst_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [7:0]         line;
    lst_pkg::lcd_mode_t mode;
    logic               coin;
    logic               vblank;
    logic               stat;
    logic               draw;
  } scan_word_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [lst_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [lst_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [5:0]                      elapsed_cycles = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [7:0]                      line_number;
  logic [1:0]                      lcd_mode;
  logic                            coincidence;
  logic                            vblank_request;
  logic                            stat_request;
  logic                            draw_strobe;

  lcd_scanline_timing dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .elapsed_cycles(elapsed_cycles),
    .out_valid(out_valid), .out_ready(out_ready),
    .line_number(line_number), .lcd_mode(lcd_mode), .coincidence(coincidence),
    .vblank_request(vblank_request), .stat_request(stat_request),
    .draw_strobe(draw_strobe)
  );

  always #10 clk = ~clk;

  // model state and register copies
  int                 timer_left;
  logic [7:0]         line_now;
  lst_pkg::lcd_mode_t last_mode;
  logic               m_enable, m_hb_en, m_vb_en, m_oam_en, m_coin_en;
  logic [7:0]         m_compare;

  logic [5:0]  cycle_words[$];
  scan_word_t  want_q[$];
  scan_word_t  seen_q[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_arm = 1'b0;
  int          hold_left = 0;
  int          err_count = 0;
  int          cycle_count = 0;

  function automatic scan_word_t next_scan_status(input logic [5:0] cyc);
    scan_word_t         w;
    lst_pkg::lcd_mode_t m;
    logic               irq_en;
    int                 offset;
    int                 nxt;
    offset = LINE_CYCLES - timer_left;
    if (line_now >= VISIBLE_LINES) m = lst_pkg::MODE_VBLANK;
    else if (offset < OAM_CYCLES) m = lst_pkg::MODE_OAM;
    else if (offset < HBLANK_START) m = lst_pkg::MODE_TRANSFER;
    else m = lst_pkg::MODE_HBLANK;
    case (m)
      lst_pkg::MODE_HBLANK: irq_en = m_hb_en;
      lst_pkg::MODE_VBLANK: irq_en = m_vb_en;
      lst_pkg::MODE_OAM:    irq_en = m_oam_en;
      default:              irq_en = 1'b0;
    endcase
    w = '0;
    w.mode = m;
    w.stat = (m != last_mode) && irq_en;
    last_mode = m;
    if (line_now == m_compare) begin
      w.coin = 1'b1;
      if (m_coin_en) w.stat = 1'b1;
    end
    if (m_enable) begin
      timer_left = timer_left - int'(cyc);
      if (timer_left <= 0) begin
        nxt = int'(line_now) + 1;
        timer_left = LINE_CYCLES;
        if (nxt == VISIBLE_LINES) w.vblank = 1'b1;
        else if (nxt > LAST_LINE) nxt = 0;
        else if (nxt < VISIBLE_LINES) w.draw = 1'b1;
        line_now = nxt[7:0];
      end
    end
    w.line = line_now;
    return w;
  endfunction

  function automatic void note_error(input string what, input scan_word_t exp,
                                     input scan_word_t got);
    err_count++;
    if (err_count <= 10)
      $display({"%0t %s: exp line=%0d mode=%0d coin=%b vbl=%b stat=%b draw=%b",
                " | got line=%0d mode=%0d coin=%b vbl=%b stat=%b draw=%b"},
               $time, what, exp.line, exp.mode, exp.coin, exp.vblank, exp.stat, exp.draw,
               got.line, got.mode, got.coin, got.vblank, got.stat, got.draw);
  endfunction

  always @(posedge clk) begin : drive_words
    logic       nxt_valid;
    logic [5:0] nxt_data;
    if (rst) begin
      in_valid <= 1'b0;
      elapsed_cycles <= '0;
    end else begin
      nxt_valid = in_valid;
      nxt_data = elapsed_cycles;
      if (in_valid && in_ready) begin
        want_q.push_back(next_scan_status(elapsed_cycles));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && cycle_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_data = cycle_words.pop_front();
        nxt_valid = 1'b1;
      end
      in_valid <= nxt_valid;
      elapsed_cycles <= nxt_data;
    end
  end

  always @(posedge clk) begin : hold_off
    if (rst) hold_left <= 0;
    else if (hold_arm) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin : watch_words
    scan_word_t got;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.line = line_number;
        got.mode = lst_pkg::lcd_mode_t'(lcd_mode);
        got.coin = coincidence;
        got.vblank = vblank_request;
        got.stat = stat_request;
        got.draw = draw_strobe;
        seen_q.push_back(got);
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(negedge clk) begin : score_words
    scan_word_t got, exp;
    while (seen_q.size() > 0) begin
      got = seen_q.pop_front();
      if (want_q.size() == 0) begin
        note_error("unexpected word", '0, got);
      end else begin
        exp = want_q.pop_front();
        if (got.line != exp.line || got.mode != exp.mode || got.coin != exp.coin ||
            got.vblank != exp.vblank || got.stat != exp.stat || got.draw != exp.draw)
          note_error("mismatch", exp, got);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [lst_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      lst_pkg::REG_LCD_ENABLE:         m_enable = data[0];
      lst_pkg::REG_LINE_COMPARE:       m_compare = data;
      lst_pkg::REG_HBLANK_IRQ_EN:      m_hb_en = data[0];
      lst_pkg::REG_VBLANK_IRQ_EN:      m_vb_en = data[0];
      lst_pkg::REG_OAM_IRQ_EN:         m_oam_en = data[0];
      lst_pkg::REG_COINCIDENCE_IRQ_EN: m_coin_en = data[0];
      default: ;
    endcase
  endtask

  // upper data bits are junk; 1-bit registers must mask them
  task automatic program_regs(input logic en, input logic [7:0] cmp, input logic hb,
                              input logic vb, input logic oam, input logic coi);
    logic [6:0] junk;
    junk = 7'($urandom);
    write_reg(lst_pkg::REG_LCD_ENABLE, {junk, en});
    write_reg(lst_pkg::REG_LINE_COMPARE, cmp);
    write_reg(lst_pkg::REG_HBLANK_IRQ_EN, {~junk, hb});
    write_reg(lst_pkg::REG_VBLANK_IRQ_EN, {junk, vb});
    write_reg(lst_pkg::REG_OAM_IRQ_EN, {~junk, oam});
    write_reg(lst_pkg::REG_COINCIDENCE_IRQ_EN, {junk, coi});
    write_reg(REG_SPARE_LO, 8'($urandom));
    write_reg(REG_SPARE_HI, 8'($urandom));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain;
    @(negedge clk);
    while (cycle_words.size() > 0 || in_valid || want_q.size() > 0 || seen_q.size() > 0)
      @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  // mostly large steps so a run crosses vblank and the frame wrap
  task automatic queue_random(input int n);
    @(negedge clk);
    repeat (n) begin
      if ($urandom_range(99) < 80) cycle_words.push_back(6'($urandom_range(63, 56)));
      else cycle_words.push_back(6'($urandom_range(63)));
    end
  endtask

  function automatic logic [7:0] pick_compare();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(LAST_LINE));
      default: return 8'($urandom_range(LAST_LINE + 2, VISIBLE_LINES - 4));
    endcase
  endfunction

  initial begin : run_test
    int ph;
    int ck;
    int idle_tab[4][2];
    idle_tab = '{'{0, 0}, '{79, 0}, '{0, 79}, '{24, 24}};
    timer_left = LINE_CYCLES;
    line_now = '0;
    last_mode = lst_pkg::MODE_HBLANK;
    m_enable = 1'b1;
    m_compare = '0;
    m_hb_en = 1'b0;
    m_vb_en = 1'b0;
    m_oam_en = 1'b0;
    m_coin_en = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // mode boundaries, exact timer run-out, then run-out with excess
    program_regs(1'b1, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
    @(negedge clk);
    cycle_words = '{6'd0, 6'd63, 6'd16, 6'd1, 6'd63, 6'd63, 6'd45, 6'd1, 6'd63, 6'd63,
                    6'd63, 6'd15, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd20};
    drain();
    // LCD off: timer and line hold
    program_regs(1'b0, 8'd1, 1'b1, 1'b1, 1'b1, 1'b1);
    @(negedge clk);
    cycle_words = '{6'd63, 6'd0, 6'd63, 6'd42};
    drain();

    for (ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      send_idle_pct = idle_tab[ph][0];
      recv_stall_pct = idle_tab[ph][1];
      for (ck = 0; ck < 4; ck++) begin
        if (ph == 0 && ck == 0)
          program_regs(1'b1, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1);
        else if (ph == 1 && ck == 0)
          program_regs(1'b1, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        else
          program_regs(ck == 3 ? 1'($urandom_range(1)) : 1'b1, pick_compare(),
                       1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        queue_random(110);
        if (ph == 0 && ck == 0) begin
          hold_arm = 1'b1;
          @(negedge clk);
          hold_arm = 1'b0;
        end
        drain();
      end
    end

    if (err_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
